/* hw/rtl/mexp_pkg.sv */
// shared constants, field widths and controller states for the modular exponentiation block
// no dependencies; compiled first
package mexp_pkg;

  localparam int MOD_W  = 31;
  localparam int BASE_W = 31;
  localparam int EXP_W  = 63;
  // bit counter of the serial multiplier, counts MOD_W-1 down to 0
  localparam int CNT_W  = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } mexp_state_t;

endpackage

/* hw/rtl/mexp_if.sv */
// valid/ready channel interfaces for the operand beat and the result beat
// depends on mexp_pkg for the field widths
interface mexp_in_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, base, exponent, input ready);
  modport sink   (input valid, base, exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

/* hw/rtl/modular_exponentiation.sv */
// top level: base^exponent mod modulus by left-to-right square-and-multiply
// depends on mexp_pkg and the channel interfaces in mexp_if.sv
//
// usage: in_ch takes one beat of base and exponent, out_ch gives one beat of
// power_result for it. cfg_we/cfg_wdata write the modulus (reset value
// 1000000007, zero behaves as one); write it only while no beat is in flight.
// every modular product runs through one bit-serial interleaved multiplier that
// consumes one multiplier bit per cycle. an item with any exponent bit set runs a
// base reduction, then EXP_BITS squarings, one per exponent bit, and a multiply
// per set exponent bit; an all-zero exponent goes straight to the result.
// one item is in flight at a time; in_ch.ready is high only when the controller
// is idle, so with out_ch keeping up the next beat can be taken in the cycle in
// which the result is first valid. the result sits in an output register, so a new
// beat is accepted while out_ch is stalled; the controller then waits at the end of
// that item until the output register is free.
// rst is synchronous: it empties the output register, returns the controller to
// idle and restores the modulus reset value.
module modular_exponentiation #(
  parameter int EXP_BITS = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  mexp_in_if.sink                  in_ch,
  mexp_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_wdata
);
  import mexp_pkg::*;

  localparam int ECNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam logic [CNT_W-1:0] MCNT_TOP = CNT_W'(MOD_W - 1);

  mexp_state_t state, state_next;

  logic [MOD_W-1:0]    modulus;
  logic [MOD_W-1:0]    acc;
  logic [MOD_W-1:0]    bred;
  logic [MOD_W-1:0]    xsr;
  logic [MOD_W-1:0]    yreg;
  logic [MOD_W-1:0]    r;
  logic [CNT_W-1:0]    mcnt;
  logic [EXP_BITS-1:0] esr;
  logic [ECNT_W-1:0]   ecnt;
  logic [MOD_W-1:0]    out_data;
  logic                out_valid;

  logic                in_ready;
  logic                busy_mul;
  logic                load_out;
  logic                in_fire;
  logic                out_free;
  logic                mul_last;
  logic                e_zero;
  logic [EXP_BITS-1:0] e_in;
  logic [MOD_W-1:0]    m_eff;
  logic [MOD_W-1:0]    one_mod;
  logic [MOD_W:0]      m_ext;
  logic [MOD_W:0]      dbl;
  logic [MOD_W:0]      dbl_red;
  logic [MOD_W:0]      sum;
  logic [MOD_W:0]      sum_red;
  logic [MOD_W-1:0]    mul_out;

  // modulus zero acts as modulus one
  assign m_eff   = (modulus == '0) ? MOD_W'(1) : modulus;
  assign one_mod = (m_eff == MOD_W'(1)) ? '0 : MOD_W'(1);
  assign m_ext   = {1'b0, m_eff};

  // interleaved multiply step: r = (2r + xbit*y) mod m, with r and y below m
  assign dbl     = {r, 1'b0};
  assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
  assign sum     = dbl_red + (xsr[MOD_W-1] ? {1'b0, yreg} : '0);
  assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  assign mul_out = sum_red[MOD_W-1:0];
  assign mul_last = (mcnt == '0);

  assign e_in     = in_ch.exponent[EXP_BITS-1:0];
  assign e_zero   = (e_in == '0);
  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = e_zero ? ST_FINISH : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (mul_last) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (mul_last) begin
          if (esr[EXP_BITS-1])   state_next = ST_MULT;
          else if (ecnt == '0)   state_next = ST_FINISH;
          else                   state_next = ST_SQUARE;
        end
      end
      ST_MULT: begin
        if (mul_last) state_next = (ecnt == '0) ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    busy_mul = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:                      in_ready = 1'b1;
      ST_REDUCE, ST_SQUARE, ST_MULT: busy_mul = 1'b1;
      ST_FINISH:                    load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      modulus   <= MODULUS_RESET;
    end else begin
      state <= state_next;
      if (load_out)          out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (cfg_we) modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    // the last step of a product is taken over by the reload below
    if (busy_mul && !mul_last) begin
      xsr  <= xsr << 1;
      r    <= mul_out;
      mcnt <= mcnt - 1'b1;
    end
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          acc  <= MOD_W'(1);
          esr  <= e_in;
          ecnt <= ECNT_W'(EXP_BITS - 1);
          // first pass reduces base below the modulus
          xsr  <= in_ch.base;
          yreg <= one_mod;
          r    <= '0;
          mcnt <= MCNT_TOP;
        end
      end
      ST_REDUCE: begin
        if (mul_last) begin
          bred <= mul_out;
          xsr  <= MOD_W'(1);
          yreg <= MOD_W'(1);
          r    <= '0;
          mcnt <= MCNT_TOP;
        end
      end
      ST_SQUARE: begin
        if (mul_last) begin
          acc  <= mul_out;
          xsr  <= mul_out;
          r    <= '0;
          mcnt <= MCNT_TOP;
          if (esr[EXP_BITS-1]) begin
            yreg <= bred;
          end else begin
            yreg <= mul_out;
            esr  <= esr << 1;
            ecnt <= ecnt - 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mul_last) begin
          acc  <= mul_out;
          xsr  <= mul_out;
          yreg <= mul_out;
          r    <= '0;
          mcnt <= MCNT_TOP;
          esr  <= esr << 1;
          ecnt <= ecnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (load_out) out_data <= acc;
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.power_result = out_data;

endmodule

/* hw/rtl/mexp_checker.sv */
// port-level checks for modular_exponentiation, attached by the bind below
// depends on mexp_pkg and binds to the channel ports of modular_exponentiation
module mexp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [mexp_pkg::EXP_W-1:0]  exponent,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mexp_pkg::MOD_W-1:0]  power_result
);
  import mexp_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power_result))
    else $error("result beat changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: no new beat right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // zero exponent goes through the finish state to the output register and answers one when the output is free
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && exponent == '0 && !out_valid
      |-> ##2 out_valid && power_result == MOD_W'(1))
    else $error("zero exponent did not give one");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .exponent     (in_ch.exponent),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .power_result (out_ch.power_result)
);

/* tb/tb_top.sv */
// self-checking bench for modular_exponentiation: directed table, then random phases
// under several modulus settings, each result checked against its table value or a square-and-multiply model
// depends on mexp_pkg and the channel interfaces in mexp_if.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mexp_pkg::*;

  localparam int  RESET_CYCLES = 5;
  localparam int  MAX_GAP      = 16;
  localparam int  HOLD_CYCLES  = 12000;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  TAIL_CYCLES  = 64;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  PHASE_ITEMS  = 15;

  localparam logic [MOD_W-1:0]  MOD_MAX  = '1;
  localparam logic [BASE_W-1:0] BASE_MAX = '1;
  localparam logic [EXP_W-1:0]  EXP_MAX  = '1;

  typedef enum logic {ROW_ITEM, ROW_MODULUS} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [MOD_W-1:0]  modulus;
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic              known;
    logic [MOD_W-1:0]  power;
  } stim_row_t;

  typedef struct {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic [MOD_W-1:0]  power;
  } pending_power_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  mexp_in_if  in_ch();
  mexp_out_if out_ch();

  modular_exponentiation dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_power_t   power_q[$];
  logic [MOD_W-1:0] modulus_copy = MODULUS_RESET;
  int               mismatches = 0;
  bit               gaps_on = 1'b0;
  bit               hold_request = 1'b0;
  longint           cycle_count = 0;

  stim_row_t directed_rows [20] = '{
    '{ROW_ITEM, '0, '0, '0, 1'b1, 31'd1},
    '{ROW_ITEM, '0, BASE_MAX, '0, 1'b1, 31'd1},
    '{ROW_ITEM, '0, 31'd2, 63'd1, 1'b1, 31'd2},
    '{ROW_ITEM, '0, '0, 63'd5, 1'b1, 31'd0},
    '{ROW_ITEM, '0, 31'd1, EXP_MAX, 1'b1, 31'd1},
    '{ROW_ITEM, '0, 31'd2, 63'd10, 1'b1, 31'd1024},
    '{ROW_ITEM, '0, 31'd1000000007, 63'd3, 1'b1, 31'd0},
    '{ROW_ITEM, '0, BASE_MAX, EXP_MAX, 1'b0, '0},
    '{ROW_ITEM, '0, 31'd12345, 63'h4000_0000_0000_0000, 1'b0, '0},
    '{ROW_MODULUS, 31'd1, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, 31'd5, '0, 1'b1, 31'd1},
    '{ROW_ITEM, '0, 31'd5, 63'd7, 1'b1, 31'd0},
    // zero modulus acts like one
    '{ROW_MODULUS, 31'd0, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, 31'd3, '0, 1'b1, 31'd1},
    '{ROW_ITEM, '0, 31'd3, 63'd1, 1'b1, 31'd0},
    '{ROW_MODULUS, MOD_MAX, '0, '0, 1'b0, '0},
    '{ROW_ITEM, '0, BASE_MAX, 63'd1, 1'b1, 31'd0},
    '{ROW_ITEM, '0, 31'h7FFF_FFFE, 63'd2, 1'b1, 31'd1},
    '{ROW_ITEM, '0, 31'h7FFF_FFFE, 63'd3, 1'b1, 31'h7FFF_FFFE},
    '{ROW_ITEM, '0, 31'd3, EXP_MAX, 1'b0, '0}
  };

  function automatic logic [MOD_W-1:0] power_mod(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e,
                                                 logic [MOD_W-1:0] m);
    logic [63:0] md;
    logic [63:0] acc;
    md  = (m == '0) ? 64'd1 : 64'(m);
    acc = 64'd1;
    if (e == '0) return 31'd1;
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % md;
      if (e[i]) acc = (acc * 64'(b)) % md;
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // called at a falling edge; leaves at the falling edge after the beat
  task automatic send_operands(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                               input logic known, input logic [MOD_W-1:0] power);
    int gap;
    pending_power_t p;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p.base     = b;
    p.exponent = e;
    p.power    = known ? power : power_mod(b, e, modulus_copy);
    power_q    = {power_q, p};
    @(negedge clk);
  endtask

  // lower valid and wait until every result beat has been taken
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (power_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    modulus_copy = value;
    @(negedge clk);
  endtask

  task automatic send_random_operands;
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    case ($urandom_range(0, 9))
      0:       b = '0;
      1:       b = BASE_MAX;
      2:       b = BASE_W'($urandom_range(0, 16));
      3:       b = modulus_copy;
      4:       b = modulus_copy - 31'd1;
      default: b = BASE_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       e = '0;
      1:       e = EXP_MAX;
      2:       e = EXP_W'($urandom_range(1, 64));
      3:       e = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
      4:       e = EXP_W'($urandom);
      default: e = EXP_W'({$urandom, $urandom});
    endcase
    send_operands(b, e, 1'b0, '0);
  endtask

  // result side: random stall per beat while gaps are on, one long hold-off on request
  initial begin
    int gap;
    pending_power_t p;
    bit hold_taken;
    out_ch.ready = 1'b0;
    hold_taken   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_request && !hold_taken) begin
        gap = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (power_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing outstanding",
                                  out_ch.power_result));
      end else begin
        p = power_q.pop_front();
        if (out_ch.power_result !== p.power)
          report_mismatch($sformatf("base %0d exponent %0d: power_result %0d, want %0d",
                                    p.base, p.exponent, out_ch.power_result, p.power));
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [MOD_W-1:0] phase_mods [8];
    in_ch.valid    = 1'b0;
    in_ch.base     = '0;
    in_ch.exponent = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_MODULUS)
        write_modulus(directed_rows[i].modulus);
      else
        send_operands(directed_rows[i].base, directed_rows[i].exponent,
                      directed_rows[i].known, directed_rows[i].power);
    end

    phase_mods = '{MODULUS_RESET, MOD_W'($urandom), MOD_W'($urandom_range(2, 64)),
                   MOD_MAX, 31'd1, MOD_W'($urandom_range(2, 131071)), 31'd0, 31'd2};
    foreach (phase_mods[ph]) begin
      write_modulus(phase_mods[ph]);
      gaps_on = ph[0];
      // long result stall: one result waits in the output register, the controller finishes one more item and waits
      if (ph == 2) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_random_operands();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* modular_exponentiation.f */
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_if.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_checker.sv
tb/tb_top.sv
